FILE: rtl/core/bths_pkg.sv
// bths_pkg: types, constants and helpers for the bracket tag histogram sort core
// no dependencies
package bths_pkg;

  localparam int CNT_W = 7;
  localparam int TXT_W = 64;
  localparam int LEN_W = 4;
  localparam int TALLY_W = 16;

  localparam logic [1:0] OP_CHAR   = 2'd0;
  localparam logic [1:0] OP_END    = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;

  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_CLOSE = 8'h5D;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

  typedef enum logic [1:0] {
    PH_SEARCH,
    PH_COLLECT,
    PH_CLOSED,
    PH_NOTAG
  } phase_t;

  typedef enum logic {
    CMD_END,
    CMD_FINISH
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic             has_tag;
    logic [TXT_W-1:0] tag;
    logic [LEN_W-1:0] len;
  } cmd_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] char_code;
  } item_t;

  typedef struct packed {
    logic               entry_valid;
    logic [CNT_W-1:0]   rank;
    logic [TXT_W-1:0]   tag_text;
    logic [LEN_W-1:0]   tag_length;
    logic [TALLY_W-1:0] tag_count;
    logic [TALLY_W-1:0] names_scanned;
    logic [CNT_W-1:0]   distinct_tags;
    logic               last;
  } result_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_M_RD,
    B_M_CMP,
    B_INS,
    B_S_LOAD_RD,
    B_S_LOAD,
    B_S_RD,
    B_S_CMP,
    B_S_END,
    B_E_RD,
    B_E_OUT
  } bstate_t;

  function automatic logic [7:0] fold(input logic [7:0] c);
    fold = (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
  endfunction

  // case-insensitive compare of the first len bytes
  function automatic logic tags_match(input logic [TXT_W-1:0] a,
                                      input logic [TXT_W-1:0] b,
                                      input logic [LEN_W-1:0] len);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < 8; i++) begin
      if (LEN_W'(i) < len && fold(a[i*8 +: 8]) != fold(b[i*8 +: 8])) begin
        ok = 1'b0;
      end
    end
    tags_match = ok;
  endfunction

endpackage

FILE: rtl/core/bths_if.sv
// bths_if: valid/ready channel interfaces for items and results
// depends on bths_pkg
interface bths_item_if;
  logic             valid;
  logic             ready;
  bths_pkg::item_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface bths_result_if;
  logic              valid;
  logic              ready;
  bths_pkg::result_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/core/bths_cmd_fifo.sv
// bths_cmd_fifo: short command queue between tag extraction and table engine
// depends on bths_pkg
module bths_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  bths_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output bths_pkg::cmd_t pop_data,
  output logic          empty
);
  import bths_pkg::*;

  cmd_t       slots [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] fill;

  assign full = (fill == 3'd4);
  assign empty = (fill == 3'd0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + 2'd1;
      end
      if (pop && !empty) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      fill <= fill + 3'((push && !full) ? 1 : 0) - 3'((pop && !empty) ? 1 : 0);
    end
  end
endmodule

FILE: rtl/core/bths_front.sv
// bths_front: accepts name bytes, extracts the bracketed tag, queues commands
// depends on bths_pkg, bths_if
module bths_front #(
  parameter int TAG_CHARS = 8
) (
  input  logic            clk,
  input  logic            rst,
  bths_item_if.sink       item,
  output logic            push,
  output bths_pkg::cmd_t  push_data,
  input  logic            full
);
  import bths_pkg::*;

  phase_t           phase;
  logic [TXT_W-1:0] cur_tag;
  logic [LEN_W-1:0] cur_len;
  logic             overlong;
  logic             beat;

  assign item.ready = !full;
  assign beat = item.valid && !full;

  always_comb begin
    push = 1'b0;
    push_data.kind = CMD_END;
    push_data.has_tag = (phase == PH_CLOSED) && !overlong;
    push_data.tag = cur_tag;
    push_data.len = cur_len;
    if (beat) begin
      case (item.payload.operation)
        OP_END: push = 1'b1;
        OP_FINISH: begin
          push = 1'b1;
          push_data.kind = CMD_FINISH;
        end
        default: push = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SEARCH;
      cur_tag <= '0;
      cur_len <= '0;
      overlong <= 1'b0;
    end else if (beat) begin
      if (item.payload.operation == OP_END || item.payload.operation == OP_FINISH) begin
        phase <= PH_SEARCH;
        cur_tag <= '0;
        cur_len <= '0;
        overlong <= 1'b0;
      end else if (item.payload.operation == OP_CHAR) begin
        if (item.payload.char_code == CH_NUL) begin
          if (phase != PH_CLOSED) begin
            phase <= PH_NOTAG;
          end
        end else if (phase == PH_SEARCH) begin
          if (item.payload.char_code == CH_OPEN) begin
            phase <= PH_COLLECT;
          end
        end else if (phase == PH_COLLECT) begin
          if (item.payload.char_code == CH_CLOSE) begin
            phase <= PH_CLOSED;
          end else if (cur_len < LEN_W'(TAG_CHARS)) begin
            cur_tag[cur_len[2:0]*8 +: 8] <= item.payload.char_code;
            cur_len <= cur_len + 1'b1;
          end else begin
            overlong <= 1'b1;
          end
        end
      end
    end
  end
endmodule

FILE: rtl/core/bths_back.sv
// bths_back: tag table in memory, match walk, bubble sort and report
// depends on bths_pkg, bths_if
module bths_back #(
  parameter int TABLE_SIZE = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [bths_pkg::CNT_W-1:0]  cfg_wr_data,
  input  bths_pkg::cmd_t              cmd,
  input  logic                        empty,
  output logic                        pop,
  bths_result_if.source               result
);
  import bths_pkg::*;

  localparam int IDX_W = $clog2(TABLE_SIZE);

  logic [TXT_W-1:0]   tag_mem [TABLE_SIZE];
  logic [LEN_W-1:0]   len_mem [TABLE_SIZE];
  logic [TALLY_W-1:0] cnt_mem [TABLE_SIZE];

  bstate_t            state;
  bstate_t            state_next;
  logic [IDX_W-1:0]   idx;
  logic [CNT_W-1:0]   used;
  logic [TALLY_W-1:0] scanned;
  logic               full;
  logic [CNT_W-1:0]   max_e;
  logic [TXT_W-1:0]   cmd_tag;
  logic [LEN_W-1:0]   cmd_len;
  logic [TXT_W-1:0]   car_tag;
  logic [LEN_W-1:0]   car_len;
  logic [TALLY_W-1:0] car_cnt;
  logic               moved;
  logic [TXT_W-1:0]   rd_tag;
  logic [LEN_W-1:0]   rd_len;
  logic [TALLY_W-1:0] rd_cnt;
  logic               out_valid;
  result_t            out_data;

  logic               we;
  logic [IDX_W-1:0]   wa;
  logic [TXT_W-1:0]   wtag;
  logic [LEN_W-1:0]   wlen;
  logic [TALLY_W-1:0] wcnt;
  logic [IDX_W-1:0]   ra;
  logic               hit;
  logic               at_end;
  logic               out_free;
  logic               out_load;
  logic [CNT_W-1:0]   lim;
  logic               room;

  assign hit = (rd_len == cmd_len) && tags_match(rd_tag, cmd_tag, cmd_len);
  assign at_end = (CNT_W'(idx) == used - 1'b1);
  assign out_free = !out_valid || result.ready;
  assign room = (used < CNT_W'(TABLE_SIZE));
  assign result.valid = out_valid;
  assign result.payload = out_data;

  always_comb begin
    lim = max_e;
    if (max_e == '0) begin
      lim = CNT_W'(1);
    end else if (max_e > CNT_W'(TABLE_SIZE)) begin
      lim = CNT_W'(TABLE_SIZE);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (!empty) begin
          if (cmd.kind == CMD_FINISH) begin
            if (used == '0) begin
              state_next = B_E_OUT;
            end else if (used == CNT_W'(1)) begin
              state_next = B_E_RD;
            end else begin
              state_next = B_S_LOAD_RD;
            end
          end else if (!full && cmd.has_tag) begin
            state_next = (used == '0) ? B_INS : B_M_RD;
          end
        end
      end
      B_M_RD: state_next = B_M_CMP;
      B_M_CMP: begin
        if (hit) begin
          state_next = B_IDLE;
        end else if (at_end) begin
          state_next = B_INS;
        end else begin
          state_next = B_M_RD;
        end
      end
      B_INS: state_next = B_IDLE;
      B_S_LOAD_RD: state_next = B_S_LOAD;
      B_S_LOAD: state_next = B_S_RD;
      B_S_RD: state_next = B_S_CMP;
      B_S_CMP: state_next = at_end ? B_S_END : B_S_RD;
      B_S_END: state_next = moved ? B_S_LOAD_RD : B_E_RD;
      B_E_RD: state_next = B_E_OUT;
      B_E_OUT: begin
        if (out_free) begin
          state_next = (used == '0 || at_end) ? B_IDLE : B_E_RD;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // memory port and handshake controls
  always_comb begin
    we = 1'b0;
    wa = idx;
    wtag = rd_tag;
    wlen = rd_len;
    wcnt = rd_cnt;
    ra = idx;
    pop = 1'b0;
    out_load = 1'b0;
    unique case (state)
      B_IDLE: pop = !empty;
      B_M_CMP: begin
        if (hit) begin
          we = 1'b1;
          wcnt = (rd_cnt == TALLY_MAX) ? rd_cnt : rd_cnt + 1'b1;
        end
      end
      B_INS: begin
        we = room;
        wa = used[IDX_W-1:0];
        wtag = cmd_tag;
        wlen = cmd_len;
        wcnt = TALLY_W'(1);
      end
      B_S_LOAD_RD: ra = '0;
      B_S_CMP: begin
        we = 1'b1;
        wa = idx - 1'b1;
        if (car_cnt >= rd_cnt) begin
          wtag = car_tag;
          wlen = car_len;
          wcnt = car_cnt;
        end
      end
      B_S_END: begin
        we = 1'b1;
        wa = idx;
        wtag = car_tag;
        wlen = car_len;
        wcnt = car_cnt;
      end
      B_E_OUT: out_load = out_free;
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      tag_mem[wa] <= wtag;
      len_mem[wa] <= wlen;
      cnt_mem[wa] <= wcnt;
    end
    rd_tag <= tag_mem[ra];
    rd_len <= len_mem[ra];
    rd_cnt <= cnt_mem[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      idx <= '0;
      used <= '0;
      scanned <= '0;
      full <= 1'b0;
      max_e <= CNT_W'(64);
      moved <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        max_e <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          idx <= '0;
          if (!empty && cmd.kind == CMD_END && !full && scanned != TALLY_MAX) begin
            scanned <= scanned + 1'b1;
          end
        end
        B_M_CMP: idx <= idx + 1'b1;
        B_INS: begin
          used <= used + CNT_W'(room);
          if (used + CNT_W'(room) >= lim) begin
            full <= 1'b1;
          end
        end
        B_S_LOAD: begin
          idx <= IDX_W'(1);
          moved <= 1'b0;
        end
        B_S_CMP: begin
          if (car_cnt < rd_cnt) begin
            moved <= 1'b1;
          end
          if (!at_end) begin
            idx <= idx + 1'b1;
          end
        end
        B_S_END: idx <= '0;
        B_E_OUT: begin
          if (out_free) begin
            if (used == '0 || at_end) begin
              used <= '0;
              scanned <= '0;
              full <= 1'b0;
              idx <= '0;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        default: idx <= idx;
      endcase
    end
  end

  // command payload, carried sort element and result register
  always_ff @(posedge clk) begin
    if (state == B_IDLE && !empty) begin
      cmd_tag <= cmd.tag;
      cmd_len <= cmd.len;
    end
    if (state == B_S_LOAD || (state == B_S_CMP && car_cnt >= rd_cnt)) begin
      car_tag <= rd_tag;
      car_len <= rd_len;
      car_cnt <= rd_cnt;
    end
    if (out_load) begin
      out_data.entry_valid <= (used != '0);
      out_data.rank <= (used != '0) ? CNT_W'(idx) + 1'b1 : '0;
      out_data.tag_text <= (used != '0) ? rd_tag : '0;
      out_data.tag_length <= (used != '0) ? rd_len : '0;
      out_data.tag_count <= (used != '0) ? rd_cnt : '0;
      out_data.names_scanned <= scanned;
      out_data.distinct_tags <= used;
      out_data.last <= (used == '0) || at_end;
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= CNT_W'(TABLE_SIZE))
    else $error("table use beyond its size");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.entry_valid |-> out_data.last)
    else $error("empty report not marked last");

  a_sort_index: assert property (@(posedge clk) disable iff (rst)
    state == B_S_CMP |-> (CNT_W'(idx) < used) && (idx != '0))
    else $error("sort step outside table");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    pop |-> state == B_IDLE)
    else $error("command taken while busy");
endmodule

FILE: rtl/core/bracket_tag_histogram_sort_core.sv
// bracket_tag_histogram_sort_core: top level of the bracket tag histogram
// depends on bths_pkg, bths_if, bths_front, bths_cmd_fifo, bths_back
//
// The extraction front end takes one name byte per cycle while the command queue
// is not full. An end of name waits in a four-entry command queue and then runs
// the match walk, which reads and then compares the table entries one by one
// from the single-read table memory. A finish runs bubble passes over the n tags
// in the table (at most n passes, stopping early on a pass without swaps), each
// step writing back the entry with the larger count and carrying the other on,
// and then reports the entries one by one. The front end keeps accepting bytes
// while the back end works, until the queue is full.
module bracket_tag_histogram_sort_core #(
  parameter int TABLE_SIZE = 64,
  parameter int TAG_CHARS = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [bths_pkg::CNT_W-1:0] cfg_wr_data,
  bths_item_if.sink                  item,
  bths_result_if.source              result
);
  import bths_pkg::*;

  logic push;
  cmd_t push_data;
  logic full;
  logic pop;
  cmd_t pop_data;
  logic empty;

  bths_front #(.TAG_CHARS(TAG_CHARS)) u_front (
    .clk(clk), .rst(rst), .item(item),
    .push(push), .push_data(push_data), .full(full)
  );

  bths_cmd_fifo u_fifo (
    .clk(clk), .rst(rst), .push(push), .push_data(push_data), .full(full),
    .pop(pop), .pop_data(pop_data), .empty(empty)
  );

  bths_back #(.TABLE_SIZE(TABLE_SIZE)) u_back (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .cmd(pop_data), .empty(empty), .pop(pop), .result(result)
  );
endmodule

FILE: tb/tb_bracket_tag_histogram_sort_core.sv
// testbench for the bracket tag histogram sort core: drives name bytes, ends and
// finishes, predicts the sorted tag report and checks every result beat
// depends on bths_pkg, bths_if and the core rtl
module tb_bracket_tag_histogram_sort_core;
  import bths_pkg::*;

  localparam int TBL = 64;
  localparam int TCH = 8;
  localparam int CYCLE_LIMIT = 2000000;
  localparam logic [1:0] OP_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [CNT_W-1:0] cfg_wr_data = '0;

  bths_item_if item_ch ();
  bths_result_if result_ch ();

  bracket_tag_histogram_sort_core #(.TABLE_SIZE(TBL), .TAG_CHARS(TCH)) dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .item(item_ch.sink), .result(result_ch.source)
  );

  always #2 clk = ~clk;

  // predictor state
  logic [TXT_W-1:0] tags_m [TBL];
  logic [LEN_W-1:0] lens_m [TBL];
  logic [TALLY_W-1:0] cnts_m [TBL];
  int used_m, scanned_m, cur_len_m, limit_reg;
  logic [TXT_W-1:0] cur_tag_m;
  phase_t phase_m;
  logic overlong_m, full_m;

  result_t report_q [$];
  int errors = 0;
  int results_seen = 0;
  int reports_seen = 0;
  int cycles = 0;
  bit quiet = 0;
  bit long_hold = 0;

  task automatic report_mismatch(input string what);
    errors++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  function automatic logic [7:0] lower(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
  endfunction

  function automatic void clear_name_m();
    cur_tag_m = '0; cur_len_m = 0; phase_m = PH_SEARCH; overlong_m = 0;
  endfunction

  function automatic void reset_m();
    used_m = 0; scanned_m = 0; full_m = 0; limit_reg = 64;
    clear_name_m();
  endfunction

  function automatic bit tag_equal(input int idx);
    if (lens_m[idx] != LEN_W'(cur_len_m)) return 0;
    for (int i = 0; i < cur_len_m; i++)
      if (lower(tags_m[idx][i*8 +: 8]) != lower(cur_tag_m[i*8 +: 8])) return 0;
    return 1;
  endfunction

  function automatic void predict_histogram(input item_t it);
    int lim, n;
    bit moved, hit;
    result_t r;
    logic [TXT_W-1:0] tt;
    logic [LEN_W-1:0] tl;
    logic [TALLY_W-1:0] tc;
    case (it.operation)
      OP_CHAR: begin
        if (!full_m) begin
          if (it.char_code == CH_NUL) begin
            if (phase_m != PH_CLOSED) phase_m = PH_NOTAG;
          end else if (phase_m == PH_SEARCH) begin
            if (it.char_code == CH_OPEN) phase_m = PH_COLLECT;
          end else if (phase_m == PH_COLLECT) begin
            if (it.char_code == CH_CLOSE) phase_m = PH_CLOSED;
            else if (cur_len_m < TCH) begin
              cur_tag_m[cur_len_m*8 +: 8] = it.char_code;
              cur_len_m++;
            end else overlong_m = 1;
          end
        end
      end
      OP_END: begin
        if (!full_m) begin
          if (scanned_m < 65535) scanned_m++;
          if (phase_m == PH_CLOSED && !overlong_m) begin
            hit = 0;
            for (int i = 0; i < used_m && !hit; i++)
              if (tag_equal(i)) begin
                hit = 1;
                if (cnts_m[i] != TALLY_MAX) cnts_m[i]++;
              end
            if (!hit) begin
              if (used_m < TBL) begin
                tags_m[used_m] = cur_tag_m; lens_m[used_m] = LEN_W'(cur_len_m);
                cnts_m[used_m] = 1; used_m++;
              end
              lim = limit_reg < 1 ? 1 : (limit_reg > TBL ? TBL : limit_reg);
              if (used_m >= lim) full_m = 1;
            end
          end
        end
        clear_name_m();
      end
      OP_FINISH: begin
        n = used_m;
        for (int p = 0; p < n; p++) begin
          moved = 0;
          for (int i = 0; i + 1 < n; i++)
            if (cnts_m[i] < cnts_m[i+1]) begin
              tt = tags_m[i]; tl = lens_m[i]; tc = cnts_m[i];
              tags_m[i] = tags_m[i+1]; lens_m[i] = lens_m[i+1]; cnts_m[i] = cnts_m[i+1];
              tags_m[i+1] = tt; lens_m[i+1] = tl; cnts_m[i+1] = tc;
              moved = 1;
            end
          if (!moved) break;
        end
        if (n == 0) begin
          r = '0; r.names_scanned = TALLY_W'(scanned_m); r.last = 1;
          report_q.push_back(r);
        end else
          for (int i = 0; i < n; i++) begin
            r.entry_valid = 1; r.rank = CNT_W'(i + 1); r.tag_text = tags_m[i];
            r.tag_length = lens_m[i]; r.tag_count = cnts_m[i];
            r.names_scanned = TALLY_W'(scanned_m); r.distinct_tags = CNT_W'(n);
            r.last = (i + 1 == n);
            report_q.push_back(r);
          end
        used_m = 0; scanned_m = 0; full_m = 0;
        clear_name_m();
      end
      default: ;
    endcase
  endfunction

  // result side: random stalls, one long hold-off, checking
  initial begin
    int gap;
    result_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (long_hold) begin
        result_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
        long_hold = 0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 5);
        result_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    result_t got, want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got = result_ch.payload;
      results_seen++;
      if (got.last) reports_seen++;
      if (report_q.size() == 0) report_mismatch("result beat with nothing expected");
      else begin
        want = report_q.pop_front();
        if (got.entry_valid !== want.entry_valid) report_mismatch("entry_valid");
        if (got.rank !== want.rank) report_mismatch($sformatf("rank %0d/%0d", got.rank, want.rank));
        if (got.tag_text !== want.tag_text)
          report_mismatch($sformatf("tag_text %h/%h", got.tag_text, want.tag_text));
        if (got.tag_length !== want.tag_length) report_mismatch("tag_length");
        if (got.tag_count !== want.tag_count)
          report_mismatch($sformatf("tag_count %0d/%0d", got.tag_count, want.tag_count));
        if (got.names_scanned !== want.names_scanned)
          report_mismatch($sformatf("names_scanned %0d/%0d",
                                    got.names_scanned, want.names_scanned));
        if (got.distinct_tags !== want.distinct_tags) report_mismatch("distinct_tags");
        if (got.last !== want.last) report_mismatch("last");
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[bracket_tag_histogram_sort_core] ERROR");
      $finish;
    end
  end

  int items_sent = 0;

  // valid stays high from one beat to the next unless a random gap drops it; callers drop it before waiting
  task automatic send_beat(input logic [1:0] op, input logic [7:0] ch);
    item_t it;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    it.operation = op; it.char_code = ch;
    item_ch.valid <= 1'b1;
    item_ch.payload <= it;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    predict_histogram(it);
    items_sent++;
  endtask

  task automatic send_name(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(OP_CHAR, s[i]);
    send_beat(OP_END, 8'h00);
  endtask

  task automatic drain_and_config(input logic [CNT_W-1:0] v);
    item_ch.valid <= 1'b0;
    while (report_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    cfg_wr_en <= 1'b1; cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    limit_reg = v;
  endtask

  // random name: optional prefix, then mostly a bracketed tag from a small alphabet, sometimes malformed or with no tag
  task automatic random_name();
    int len, k;
    logic [7:0] c;
    k = $urandom_range(0, 9);
    repeat ($urandom_range(0, 2)) send_beat(OP_CHAR, 8'($urandom_range(8'h61, 8'h7A)));
    if (k == 0) begin
      repeat ($urandom_range(0, 4)) send_beat(OP_CHAR, 8'($urandom_range(0, 255)));
      send_beat(OP_END, 8'($urandom_range(0, 255)));
      return;
    end
    send_beat(OP_CHAR, CH_OPEN);
    len = (k == 1) ? $urandom_range(9, 11) : $urandom_range(0, 3);
    for (int i = 0; i < len; i++) begin
      c = (k == 2) ? 8'($urandom_range(1, 255))
                   : 8'(($urandom_range(0, 1) ? 8'h41 : 8'h62) + $urandom_range(0, 1));
      send_beat(OP_CHAR, c);
    end
    if (k != 3) send_beat(OP_CHAR, CH_CLOSE);
    if (k == 4) send_beat(OP_CHAR, CH_NUL);
    send_beat(OP_END, 8'h00);
  endtask

  typedef struct {
    logic [1:0] op;
    logic [7:0] ch;
  } stim_row_t;

  stim_row_t directed_rows [] = '{
    '{OP_FINISH, 8'h00},                       // empty table report
    '{OP_CHAR, CH_OPEN}, '{OP_CHAR, CH_CLOSE}, '{OP_END, 8'h00},  // empty tag
    '{OP_CHAR, CH_OPEN}, '{OP_CHAR, 8'h41}, '{OP_CHAR, CH_CLOSE}, '{OP_END, 8'hFF},
    '{OP_CHAR, CH_OPEN}, '{OP_CHAR, 8'h61}, '{OP_CHAR, CH_CLOSE}, '{OP_END, 8'h00},
    '{OP_CHAR, 8'hFF}, '{OP_END, 8'h00},       // no tag
    '{OP_CHAR, CH_OPEN}, '{OP_CHAR, CH_NUL}, '{OP_CHAR, CH_CLOSE}, '{OP_END, 8'h00},
    '{OP_CHAR, CH_OPEN}, '{OP_CHAR, 8'hFF},    // unfinished name dropped
    '{OP_SPARE, 8'hAA},                        // unused opcode
    '{OP_FINISH, 8'h55}
  };

  initial begin
    result_t r;
    item_ch.valid <= 1'b0;
    item_ch.payload <= '0;
    reset_m();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // first finish has a fixed answer
    r = '0; r.last = 1;
    foreach (directed_rows[i]) begin
      send_beat(directed_rows[i].op, directed_rows[i].ch);
      if (i == 0 && report_q.size() == 1 && report_q[0] != r) report_mismatch("empty report");
    end

    // overlong tag, full table at limit 1 dropping the later tags such as a recased [zZ]
    drain_and_config(7'd0);
    send_name("x[ABCDEFGHI]");
    send_name("[Zz]");
    send_name("[zZ]");
    send_name("[q]");
    send_beat(OP_FINISH, 8'h00);

    // one-byte tags until the table fills at the configured limit
    drain_and_config(7'd12);
    for (int i = 0; i < 14; i++) begin
      send_beat(OP_CHAR, CH_OPEN);
      send_beat(OP_CHAR, 8'(8'h80 + i));
      send_beat(OP_CHAR, CH_CLOSE);
      send_beat(OP_END, 8'h00);
    end
    send_beat(OP_FINISH, 8'h00);

    // receiver holds off during a report while the sender keeps going
    drain_and_config(7'd64);
    for (int i = 0; i < 6; i++) random_name();
    send_beat(OP_FINISH, 8'h00);
    long_hold = 1;
    for (int i = 0; i < 10; i++) random_name();
    send_beat(OP_FINISH, 8'h00);

    for (int ph = 0; ph < 4; ph++) begin
      drain_and_config(ph == 0 ? 7'd3 : (ph == 1 ? 7'd1 : (ph == 2 ? 7'd127 : 7'd20)));
      if (ph == 3) quiet = 1;
      while (items_sent < 215 + ph * 6) random_name();
      send_beat(OP_FINISH, 8'h00);
    end

    item_ch.valid <= 1'b0;
    while (report_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("sent %0d item beats, checked %0d result beats in %0d reports",
             items_sent, results_seen, reports_seen);
    if (errors == 0) $display("[bracket_tag_histogram_sort_core] OK");
    else $display("[bracket_tag_histogram_sort_core] ERROR");
    $finish;
  end

endmodule
